>>> rtl/pfdr_pkg.sv
// ----------------------------------------------------------------------------
// pfdr_pkg: shared definitions for the shadow framebuffer refresh block
// geometry constants, function codes, row state codes and interface types
// ----------------------------------------------------------------------------
package pfdr_pkg;

    localparam int ROW_COUNT     = 32;
    localparam int WORDS_PER_ROW = 10;
    localparam int WORD_BITS     = 16;
    localparam int COL_LIMIT     = WORDS_PER_ROW * 16;

    localparam int ROW_IDX_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int WORD_IDX_W = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

    // function codes
    localparam logic [1:0] FN_PIXEL  = 2'd0;
    localparam logic [1:0] FN_FLUSH  = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;  // ignored by the block

    // per-row state: what a stored row really holds
    localparam logic [1:0] ROW_ZERO      = 2'd0;  // words zero, nothing dirty
    localparam logic [1:0] ROW_ALL_DIRTY = 2'd1;  // words zero, every word dirty
    localparam logic [1:0] ROW_LIVE      = 2'd2;  // memory contents are current

    localparam logic [7:0] ADDR_CMD = 8'h80;

    typedef logic [WORDS_PER_ROW-1:0][WORD_BITS-1:0] t_row_words;
    typedef logic [WORDS_PER_ROW-1:0]                t_row_dirty;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic                 clear_all;
        logic [ROW_IDX_W-1:0] row;
    } t_store_req;

endpackage

>>> rtl/pfdr_row_store.sv
// ----------------------------------------------------------------------------
// pfdr_row_store: row-wide shadow memory with per-row state flags
// one row (all words plus dirty marks) per entry, registered read port
// ----------------------------------------------------------------------------
module pfdr_row_store
    import pfdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    input  t_row_words i_wr_words,
    input  t_row_dirty i_wr_dirty,
    output t_row_words o_words,
    output t_row_dirty o_dirty
);

    localparam int ENTRY_BITS = WORDS_PER_ROW * (WORD_BITS + 1);

    logic [ENTRY_BITS-1:0]      mem [ROW_COUNT];
    logic [ENTRY_BITS-1:0]      r_rd_data;
    logic [1:0]                 r_rd_flag;
    logic [ROW_COUNT-1:0][1:0]  r_flag;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.row] <= {i_wr_dirty, i_wr_words};
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.row];
        end
    end

    // row flags: reset and clear-all act on every row at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag    <= {ROW_COUNT{ROW_ZERO}};
            r_rd_flag <= ROW_ZERO;
        end else begin
            if (i_req.clear_all) begin
                r_flag <= {ROW_COUNT{ROW_ALL_DIRTY}};
            end else if (i_req.wr_en) begin
                r_flag[i_req.row] <= ROW_LIVE;
            end
            if (i_req.rd_en) begin
                r_rd_flag <= r_flag[i_req.row];
            end
        end
    end

    always_comb begin
        case (r_rd_flag)
            ROW_LIVE: begin
                o_words = r_rd_data[WORDS_PER_ROW*WORD_BITS-1:0];
                o_dirty = r_rd_data[ENTRY_BITS-1:WORDS_PER_ROW*WORD_BITS];
            end
            ROW_ALL_DIRTY: begin
                o_words = '0;
                o_dirty = '1;
            end
            default: begin
                o_words = '0;
                o_dirty = '0;
            end
        endcase
    end

endmodule

>>> rtl/pfdr_word_unit.sv
// ----------------------------------------------------------------------------
// pfdr_word_unit: shared word select, pixel modify and dirty scan logic
// used by pixel writes (bit update) and row flushes (word pick, tail check)
// ----------------------------------------------------------------------------
module pfdr_word_unit
    import pfdr_pkg::*;
(
    input  t_row_words            i_words,
    input  t_row_dirty            i_dirty,
    input  logic [WORD_IDX_W-1:0] i_idx,
    input  logic [3:0]            i_bit,
    input  logic                  i_value,
    output logic [WORD_BITS-1:0]  o_sel_word,
    output logic                  o_sel_dirty,
    output logic                  o_rest_dirty,
    output logic                  o_changed,
    output t_row_words            o_new_words,
    output t_row_dirty            o_new_dirty
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] new_word;
    t_row_dirty           tail;

    always_comb begin
        o_sel_word  = i_words[i_idx];
        o_sel_dirty = i_dirty[i_idx];
        // pixel at col mod 16 lives at bit 15 minus that
        mask        = 16'h8000 >> i_bit;
        o_changed   = ((o_sel_word & mask) != '0) != i_value;
        new_word    = i_value ? (o_sel_word | mask) : (o_sel_word & ~mask);
        // any dirty word to the right of the current one
        tail         = (i_dirty >> i_idx) >> 1;
        o_rest_dirty = (tail != '0);

        o_new_words = i_words;
        o_new_dirty = i_dirty;
        for (int k = 0; k < WORDS_PER_ROW; k++) begin
            if (WORD_IDX_W'(k) == i_idx) begin
                o_new_words[k] = new_word;
                o_new_dirty[k] = i_dirty[k] | o_changed;
            end
        end
    end

endmodule

>>> rtl/pixel_framebuffer_dirty_refresh.sv
// ----------------------------------------------------------------------------
// pixel_framebuffer_dirty_refresh: shadow graphic framebuffer with row flush
// keeps a copy of the display memory with dirty marks, emits bus bytes
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) takes one command word: pixel
//   write, row flush or clear-all. output channel (o_out_valid / i_out_ready)
//   carries the bus bytes of a flush for each dirty word, o_last on the final one.
//   o_in_ready is high only while the sequencer is idle; one command at a time.
// sequence
//   clear-all: no output. pixel write: read the row, then modify it and write
//   it back if the bit changes. out-of-range commands: nothing changes.
//   row flush: the scan steps one word a cycle through the shared word unit
//   while words are clean and stops after the last dirty word; each dirty
//   word pauses the scan while its bytes go through the output register.
// reset
//   all rows read back as zero and clean right after reset; no clearing pass
//   is needed because each row carries a state flag in flip-flops.
// stalls
//   a stalled receiver holds the current byte in the output register and the
//   sequencer waits; no byte is dropped or repeated.
// ----------------------------------------------------------------------------
module pixel_framebuffer_dirty_refresh
    import pfdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_pixel_col,
    input  logic [7:0] i_pixel_row,
    input  logic       i_pixel_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_bus_byte,
    output logic       o_is_data,
    output logic       o_last
);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_READ     = 4'd1;
    localparam logic [3:0] S_MODIFY   = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_CMD_ROW  = 4'd4;
    localparam logic [3:0] S_CMD_WORD = 4'd5;
    localparam logic [3:0] S_DATA_HI  = 4'd6;
    localparam logic [3:0] S_DATA_LO  = 4'd7;
    localparam logic [3:0] S_WRITE    = 4'd8;

    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORDS_PER_ROW - 1);

    logic [3:0]            r_state, n_state;
    logic                  r_is_flush, n_is_flush;
    logic [ROW_IDX_W-1:0]  r_row, n_row;
    logic [3:0]            r_bit, n_bit;
    logic                  r_value, n_value;
    logic [WORD_IDX_W-1:0] r_word, n_word;
    logic                  r_contig, n_contig;   // previous word went out in this flush

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_is_data;
    logic       r_out_last;

    t_store_req store_req;
    t_row_words rd_words;
    t_row_dirty rd_dirty;
    t_row_words wr_words;
    t_row_dirty wr_dirty;

    logic [WORD_BITS-1:0] sel_word;
    logic                 sel_dirty;
    logic                 rest_dirty;
    logic                 changed;
    t_row_words           new_words;
    t_row_dirty           new_dirty;

    logic       in_accept;
    logic       row_ok;
    logic       col_ok;
    logic       emitting;
    logic       out_take;
    logic       emit_go;
    logic [7:0] emit_byte;
    logic       emit_is_data;
    logic       emit_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign row_ok     = ({1'b0, i_pixel_row} < 9'(ROW_COUNT));
    assign col_ok     = ({1'b0, i_pixel_col} < 9'(COL_LIMIT));

    pfdr_row_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .i_wr_words (wr_words),
        .i_wr_dirty (wr_dirty),
        .o_words    (rd_words),
        .o_dirty    (rd_dirty)
    );

    // one word unit serves both the pixel update and the flush scan
    pfdr_word_unit u_word (
        .i_words      (rd_words),
        .i_dirty      (rd_dirty),
        .i_idx        (r_word),
        .i_bit        (r_bit),
        .i_value      (r_value),
        .o_sel_word   (sel_word),
        .o_sel_dirty  (sel_dirty),
        .o_rest_dirty (rest_dirty),
        .o_changed    (changed),
        .o_new_words  (new_words),
        .o_new_dirty  (new_dirty)
    );

    // flush write-back keeps the words and clears every mark of the row
    assign wr_words = r_is_flush ? rd_words : new_words;
    assign wr_dirty = r_is_flush ? '0 : new_dirty;

    // output stage: a new byte may load when the register is empty or draining
    assign emitting = (r_state == S_CMD_ROW) || (r_state == S_CMD_WORD) ||
                      (r_state == S_DATA_HI) || (r_state == S_DATA_LO);
    assign out_take = !r_out_valid || i_out_ready;
    assign emit_go  = emitting && out_take;

    always_comb begin
        emit_byte    = sel_word[7:0];
        emit_is_data = 1'b1;
        emit_last    = 1'b0;
        case (r_state)
            S_CMD_ROW: begin
                emit_byte    = ADDR_CMD | 8'(r_row);
                emit_is_data = 1'b0;
            end
            S_CMD_WORD: begin
                emit_byte    = ADDR_CMD | 8'(r_word);
                emit_is_data = 1'b0;
            end
            S_DATA_HI: begin
                emit_byte = sel_word[15:8];
            end
            S_DATA_LO: begin
                emit_byte = sel_word[7:0];
                emit_last = !rest_dirty;
            end
            default: begin
                emit_byte = sel_word[7:0];
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_is_flush = r_is_flush;
        n_row      = r_row;
        n_bit      = r_bit;
        n_value    = r_value;
        n_word     = r_word;
        n_contig   = r_contig;

        store_req.rd_en     = 1'b0;
        store_req.wr_en     = 1'b0;
        store_req.clear_all = 1'b0;
        store_req.row       = r_row;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_func)
                        FN_PIXEL: begin
                            if (row_ok && col_ok) begin
                                n_state    = S_READ;
                                n_is_flush = 1'b0;
                                n_row      = ROW_IDX_W'(i_pixel_row);
                                n_word     = WORD_IDX_W'(i_pixel_col[7:4]);
                                n_bit      = i_pixel_col[3:0];
                                n_value    = i_pixel_value;
                            end
                        end
                        FN_FLUSH: begin
                            if (row_ok) begin
                                n_state    = S_READ;
                                n_is_flush = 1'b1;
                                n_row      = ROW_IDX_W'(i_pixel_row);
                                n_word     = '0;
                                n_contig   = 1'b0;
                            end
                        end
                        FN_CLEAR: begin
                            store_req.clear_all = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                store_req.rd_en = 1'b1;
                n_state         = r_is_flush ? S_SCAN : S_MODIFY;
            end
            S_MODIFY: begin
                // only a real bit change touches the row
                store_req.wr_en = changed;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                if (sel_dirty) begin
                    n_state = r_contig ? S_DATA_HI : S_CMD_ROW;
                end else begin
                    n_contig = 1'b0;
                    if (r_word == WORD_LAST) begin
                        n_state = S_WRITE;
                    end else begin
                        n_word = r_word + 1'b1;
                    end
                end
            end
            S_CMD_ROW: begin
                if (emit_go) begin
                    n_state = S_CMD_WORD;
                end
            end
            S_CMD_WORD: begin
                if (emit_go) begin
                    n_state = S_DATA_HI;
                end
            end
            S_DATA_HI: begin
                if (emit_go) begin
                    n_state = S_DATA_LO;
                end
            end
            S_DATA_LO: begin
                if (emit_go) begin
                    n_contig = 1'b1;
                    if (!rest_dirty) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SCAN;
                        n_word  = r_word + 1'b1;
                    end
                end
            end
            S_WRITE: begin
                store_req.wr_en = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_is_flush  <= 1'b0;
            r_contig    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_flush <= n_is_flush;
            r_contig   <= n_contig;
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_bit   <= n_bit;
        r_value <= n_value;
        r_word  <= n_word;
        if (emit_go) begin
            r_out_byte    <= emit_byte;
            r_out_is_data <= emit_is_data;
            r_out_last    <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bus_byte  = r_out_byte;
    assign o_is_data   = r_out_is_data;
    assign o_last      = r_out_last;

    // an in-range pixel write is done after its read and modify states
    a_pixel_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_func == FN_PIXEL && row_ok && col_ok) |-> ##3 o_in_ready)
        else $error("pixel write did not finish in three cycles");

    // clear-all and unused codes leave the sequencer idle
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_func == FN_CLEAR || i_func == FN_UNUSED)) |=> o_in_ready)
        else $error("clear-all left the idle state");

    // a flush of a row beyond the display starts nothing
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_func == FN_FLUSH && !row_ok) |=> o_in_ready)
        else $error("out-of-range flush started a scan");

    // the final byte of a flush is always a data byte
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> o_is_data)
        else $error("last marker on a command byte");

    // no byte is loaded while the sequencer sits idle
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !o_out_valid) |=> !o_out_valid)
        else $error("output word appeared with no flush running");

endmodule
